// ===== hw/rtl/palc_pkg.sv =====
// Shared types and constants for the PIN attempt lockout controller.
package palc_pkg;

  // Field widths.
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned OUTCOME_W = 2;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned DUR_W     = 31;
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned CFG_IDX_W = 2;

  // Highest lockout level; each level doubles the lockout length.
  localparam int unsigned LEVEL_CAP = 16;
  localparam int unsigned LEVEL_W   = $clog2(LEVEL_CAP + 1);
  localparam int unsigned SHIFT_W   = (LEVEL_CAP > 1) ? $clog2(LEVEL_CAP) : 1;
  // Base duration shifted by up to LEVEL_CAP - 1 places, no bits lost.
  localparam int unsigned WIDE_W    = DUR_W + LEVEL_CAP - 1;

  // Event kinds.
  localparam logic [KIND_W-1:0] KIND_INIT     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_UNLOCK   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ACTIVITY = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CHECK    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LOCK     = 3'd4;

  // Verification outcomes.
  localparam logic [OUTCOME_W-1:0] OUTCOME_MATCH    = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUTCOME_MISMATCH = 2'd1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ATTEMPT_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_BASE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_CAP   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT    = 2'd3;

  // Configuration values after reset.
  localparam logic [COUNT_W-1:0] ATTEMPT_LIMIT_RST = 4'd5;
  localparam logic [DUR_W-1:0]   LOCKOUT_BASE_RST  = 31'd30000;
  localparam logic [DUR_W-1:0]   LOCKOUT_CAP_RST   = 31'd900000;
  localparam logic [DUR_W-1:0]   IDLE_LIMIT_RST    = 31'd120000;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_LOCKED   = 3'd1,
    ST_BAD_PIN  = 3'd2,
    ST_WRONG    = 3'd3,
    ST_FAILURE  = 3'd4,
    ST_ACK      = 3'd5
  } status_t;

  typedef struct packed {
    status_t              status;
    logic [DUR_W-1:0]     remaining_ms;
    logic [COUNT_W-1:0]   failed_count;
    logic                 session_open;
    logic                 new_session;
  } result_t;

endpackage

// ===== hw/rtl/pin_attempt_lockout_controller.sv =====
// Top level of the PIN attempt lockout controller: state update, lockout timing, result buffer.
//
//   channel   direction  handshake                   payload
//   event     in         event_valid / event_stall   kind, now_ms, format_ok, verify_outcome
//   result    out        result_valid / result_stall status, remaining_ms, failed_count,
//                                                    session_open, new_session
//   config    in         cfg_we                      cfg_index, cfg_data
//
// Every event beat is handled in the cycle it is accepted: the session, counter, level and
// lockout registers take their new values at that edge, and the result beat is registered.
// One event per cycle is sustained while the result side takes results without stalling.
// A two-entry result buffer (output register plus skid register) lets an event be accepted
// while one result is still waiting; event_stall rises only when both entries are full.
// Reset (synchronous, active high) empties the buffer, closes the session, clears the
// counter, level and lockout and loads the configuration defaults.
module pin_attempt_lockout_controller
  import palc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,

  input  logic                 event_valid,
  output logic                 event_stall,
  input  logic [KIND_W-1:0]    kind,
  input  logic [TIME_W-1:0]    now_ms,
  input  logic                 format_ok,
  input  logic [OUTCOME_W-1:0] verify_outcome,

  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [STATUS_W-1:0]  status,
  output logic [DUR_W-1:0]     remaining_ms,
  output logic [COUNT_W-1:0]   failed_count,
  output logic                 session_open,
  output logic                 new_session,

  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DUR_W-1:0]     cfg_data
);

  // Configuration registers.
  logic [COUNT_W-1:0] attempt_limit;
  logic [DUR_W-1:0]   lockout_base;
  logic [DUR_W-1:0]   lockout_cap_ms;
  logic [DUR_W-1:0]   idle_limit_ms;

  // Controller state and the values it takes after the current event.
  logic               unlocked,         unlocked_next;
  logic [TIME_W-1:0]  activity_stamp,   activity_stamp_next;
  logic               activity_valid,   activity_valid_next;
  logic [COUNT_W-1:0] wrong_count,      wrong_count_next;
  logic [LEVEL_W-1:0] penalty_level,    penalty_level_next;
  logic [TIME_W-1:0]  lockout_deadline, lockout_deadline_next;
  logic               lockout_on,       lockout_on_next;

  // Result buffer.
  result_t out_buf;
  result_t skid_buf;
  logic    skid_valid;
  result_t result_next;

  logic accept;
  logic take;

  // Lockout timing.
  logic [TIME_W-1:0]  deadline_diff;
  logic               lock_active;
  logic [COUNT_W-1:0] wrong_inc;
  logic [LEVEL_W-1:0] level_up;
  logic [SHIFT_W-1:0] shift_amt;
  logic [WIDE_W-1:0]  base_wide;
  logic [WIDE_W-1:0]  base_shifted;
  logic [WIDE_W-1:0]  half_cap_wide;
  logic [DUR_W-1:0]   lock_len;
  logic [TIME_W-1:0]  idle_time;

  assign event_stall = skid_valid;
  assign accept      = event_valid & ~skid_valid;
  assign take        = result_valid & ~result_stall;

  // The deadline is still ahead when deadline - now is positive as a signed 32-bit value.
  assign deadline_diff = lockout_deadline - now_ms;
  assign lock_active   = lockout_on && (deadline_diff != '0) && !deadline_diff[TIME_W-1];

  assign wrong_inc = wrong_count + COUNT_W'(1);
  assign level_up  = (penalty_level < LEVEL_W'(LEVEL_CAP)) ?
                     penalty_level + LEVEL_W'(1) : penalty_level;
  // level_up is never zero, so the shift is level minus one.
  assign shift_amt = SHIFT_W'(level_up - LEVEL_W'(1));

  // Doubling stops at the cap as soon as the previous length reached half the cap
  // (rounded down). Since the length only grows, looking at the last doubling
  // is enough: if it stayed below half the cap, the final length is below the cap.
  assign base_wide     = WIDE_W'(lockout_base);
  assign base_shifted  = base_wide << shift_amt;
  assign half_cap_wide = WIDE_W'(lockout_cap_ms >> 1);

  always_comb begin
    if (shift_amt == '0) begin
      lock_len = (lockout_base > lockout_cap_ms) ? lockout_cap_ms : lockout_base;
    end else if ((base_shifted >> 1) >= half_cap_wide) begin
      lock_len = lockout_cap_ms;
    end else begin
      lock_len = base_shifted[DUR_W-1:0];
    end
  end

  assign idle_time = now_ms - activity_stamp;

  // Next state and result for the event on the input ports.
  always_comb begin
    unlocked_next         = unlocked;
    activity_stamp_next   = activity_stamp;
    activity_valid_next   = activity_valid;
    wrong_count_next      = wrong_count;
    penalty_level_next    = penalty_level;
    lockout_deadline_next = lockout_deadline;
    lockout_on_next       = lockout_on;

    result_next              = '0;
    result_next.status       = ST_ACK;

    case (kind)
      KIND_INIT: begin
        unlocked_next         = 1'b0;
        activity_stamp_next   = '0;
        activity_valid_next   = 1'b0;
        wrong_count_next      = '0;
        penalty_level_next    = '0;
        lockout_deadline_next = '0;
        lockout_on_next       = 1'b0;
      end
      KIND_UNLOCK: begin
        if (lock_active) begin
          result_next.status       = ST_LOCKED;
          result_next.remaining_ms = deadline_diff[DUR_W-1:0];
        end else begin
          // Any lockout left at this point has run out.
          lockout_on_next = 1'b0;
          if (!format_ok) begin
            result_next.status = ST_BAD_PIN;
          end else if (verify_outcome == OUTCOME_MATCH) begin
            unlocked_next           = 1'b1;
            activity_stamp_next     = now_ms;
            activity_valid_next     = 1'b1;
            wrong_count_next        = '0;
            penalty_level_next      = '0;
            lockout_deadline_next   = '0;
            result_next.status      = ST_OK;
            result_next.new_session = 1'b1;
          end else if (verify_outcome == OUTCOME_MISMATCH) begin
            if (wrong_inc >= attempt_limit) begin
              wrong_count_next         = '0;
              penalty_level_next       = level_up;
              lockout_deadline_next    = now_ms + TIME_W'(lock_len);
              lockout_on_next          = 1'b1;
              result_next.status       = ST_LOCKED;
              result_next.remaining_ms = lock_len;
            end else begin
              wrong_count_next         = wrong_inc;
              result_next.status       = ST_WRONG;
              result_next.failed_count = wrong_inc;
            end
          end else begin
            result_next.status = ST_FAILURE;
          end
        end
      end
      KIND_ACTIVITY: begin
        if (unlocked) begin
          activity_stamp_next = now_ms;
          activity_valid_next = 1'b1;
        end
      end
      KIND_CHECK: begin
        if (unlocked && activity_valid && (idle_time > TIME_W'(idle_limit_ms))) begin
          unlocked_next       = 1'b0;
          activity_stamp_next = '0;
          activity_valid_next = 1'b0;
        end
      end
      KIND_LOCK: begin
        unlocked_next       = 1'b0;
        activity_stamp_next = '0;
        activity_valid_next = 1'b0;
      end
      default: begin
        // Unused kinds are acknowledged and change nothing.
      end
    endcase

    result_next.session_open = unlocked_next;
  end

  // Configuration, controller state and result buffer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      attempt_limit    <= ATTEMPT_LIMIT_RST;
      lockout_base     <= LOCKOUT_BASE_RST;
      lockout_cap_ms   <= LOCKOUT_CAP_RST;
      idle_limit_ms    <= IDLE_LIMIT_RST;
      unlocked         <= 1'b0;
      activity_stamp   <= '0;
      activity_valid   <= 1'b0;
      wrong_count      <= '0;
      penalty_level    <= '0;
      lockout_deadline <= '0;
      lockout_on       <= 1'b0;
      result_valid     <= 1'b0;
      skid_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ATTEMPT_LIMIT: attempt_limit  <= cfg_data[COUNT_W-1:0];
          CFG_LOCKOUT_BASE:  lockout_base   <= cfg_data;
          CFG_LOCKOUT_CAP:   lockout_cap_ms <= cfg_data;
          CFG_IDLE_LIMIT:    idle_limit_ms  <= cfg_data;
          default: begin
          end
        endcase
      end

      if (accept) begin
        unlocked         <= unlocked_next;
        activity_stamp   <= activity_stamp_next;
        activity_valid   <= activity_valid_next;
        wrong_count      <= wrong_count_next;
        penalty_level    <= penalty_level_next;
        lockout_deadline <= lockout_deadline_next;
        lockout_on       <= lockout_on_next;
      end

      // A new beat lands in the output register when that register is free by the
      // edge, otherwise in the skid register (accept implies the skid is empty).
      // Without a new beat, a taken result is refilled from the skid register if
      // it holds one.
      if (accept) begin
        if (result_valid && !take) begin
          skid_valid <= 1'b1;
        end else begin
          result_valid <= 1'b1;
        end
      end else if (take) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else begin
          result_valid <= 1'b0;
        end
      end
    end
  end

  // Result payload; no reset needed.
  always_ff @(posedge clk) begin
    if (take && skid_valid) begin
      out_buf <= skid_buf;
    end else if (accept && (!result_valid || take)) begin
      out_buf <= result_next;
    end
    if (accept && result_valid && !take) begin
      skid_buf <= result_next;
    end
  end

  assign status       = out_buf.status;
  assign remaining_ms = out_buf.remaining_ms;
  assign failed_count = out_buf.failed_count;
  assign session_open = out_buf.session_open;
  assign new_session  = out_buf.new_session;

endmodule

// ===== hw/rtl/palc_checker.sv =====
// Port-level checks for the PIN attempt lockout controller, bound to its top level.
module palc_checker
  import palc_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 event_stall,
  input logic                 result_valid,
  input logic                 result_stall,
  input logic [STATUS_W-1:0]  status,
  input logic [DUR_W-1:0]     remaining_ms,
  input logic [COUNT_W-1:0]   failed_count,
  input logic                 session_open,
  input logic                 new_session
);

  // Reset leaves no result beat behind and does not stall the event side.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!result_valid && !event_stall))
    else $error("result or stall present after reset");

  // A successful unlock always reports an open session with status ok.
  a_new_session: assert property (@(posedge clk) disable iff (rst)
    (result_valid && new_session) |-> (session_open && (status == ST_OK)))
    else $error("new session without ok status and open session");

  // Remaining time is only reported with a lockout answer.
  a_remaining: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (status != ST_LOCKED)) |-> (remaining_ms == '0))
    else $error("remaining time outside a lockout answer");

  // A failed count is only reported with a wrong-pin answer, and is never zero there.
  a_failed: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((failed_count != '0) == (status == ST_WRONG)))
    else $error("failed count does not match wrong-pin status");

  // A stalled result beat holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=>
      (result_valid && $stable(status) && $stable(remaining_ms) &&
       $stable(failed_count) && $stable(session_open) && $stable(new_session)))
    else $error("stalled result beat changed");

endmodule

bind pin_attempt_lockout_controller palc_checker u_palc_checker (.*);
